[hw/rtl/iibm_pkg.sv]
// ----------------------------------------------------------------------------
// iibm_pkg
// Shared types and constants for the integral image box mean block.
// ----------------------------------------------------------------------------
`default_nettype none

package iibm_pkg;

  localparam int unsigned MaxWidth  = 512;
  localparam int unsigned MaxHeight = 512;
  localparam int unsigned MaxHalf   = 15;

  localparam int unsigned XW   = $clog2(MaxWidth);
  localparam int unsigned YW   = $clog2(MaxHeight);
  localparam int unsigned AW   = XW + YW;
  localparam int unsigned TW   = 26;
  localparam int unsigned SUMW = 18;
  localparam int unsigned CNTW = 10;
  localparam int unsigned MW   = 16;
  localparam int unsigned QD   = 2;

  localparam logic [1:0] CfgWidth  = 2'd0;
  localparam logic [1:0] CfgHeight = 2'd1;
  localparam logic [1:0] CfgHalf   = 2'd2;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StRange = 2'd1;
  localparam logic [1:0] StEarly = 2'd2;

  // Work item passed from front to back.
  typedef struct packed {
    logic          is_query;
    logic [1:0]    status;
    logic [7:0]    pixel;
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    logic          row_start;
    logic [XW-1:0] x0;
    logic [XW-1:0] x1;
    logic [YW-1:0] y0;
    logic [YW-1:0] y1;
  } work_t;

endpackage

`default_nettype wire

[hw/rtl/iibm_front.sv]
// ----------------------------------------------------------------------------
// iibm_front
// Accepts commands, tracks raster position, clips query windows.
// ----------------------------------------------------------------------------
`default_nettype none

module iibm_front import iibm_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          restart_i,
  input  wire logic          take_i,
  input  wire logic          cmd_i,
  input  wire logic [7:0]    pixel_i,
  input  wire logic [XW-1:0] query_x_i,
  input  wire logic [YW-1:0] query_y_i,
  input  wire logic [XW:0]   w_i,
  input  wire logic [YW:0]   h_i,
  input  wire logic [3:0]    r_i,
  output work_t              item_o
);

  logic [XW-1:0] col_q, col_d;
  logic [YW-1:0] row_q, row_d;
  logic          done_q, done_d;
  logic [XW-1:0] lx;
  logic [YW-1:0] ly;
  logic [XW+1:0] xs;
  logic [YW+1:0] ys;

  always_comb begin
    lx = col_q;
    ly = row_q;
    if (done_q || ({1'b0, col_q} >= w_i) || ({1'b0, row_q} >= h_i)) begin
      lx = '0;
      ly = '0;
    end
    xs = {2'b0, query_x_i} + {{(XW-2){1'b0}}, r_i};
    ys = {2'b0, query_y_i} + {{(YW-2){1'b0}}, r_i};
  end

  always_comb begin
    item_o = '0;
    item_o.is_query  = cmd_i;
    item_o.pixel     = pixel_i;
    item_o.x         = lx;
    item_o.y         = ly;
    item_o.row_start = (lx == '0);
    if (!done_q) begin
      item_o.status = StEarly;
    end else if (({1'b0, query_x_i} >= w_i) || ({1'b0, query_y_i} >= h_i)) begin
      item_o.status = StRange;
    end else begin
      item_o.status = StOk;
    end
    item_o.x0 = (query_x_i > XW'(r_i)) ? query_x_i - XW'(r_i) : '0;
    item_o.y0 = (query_y_i > YW'(r_i)) ? query_y_i - YW'(r_i) : '0;
    item_o.x1 = (xs < {1'b0, w_i}) ? xs[XW-1:0] : XW'(w_i - 1'b1);
    item_o.y1 = (ys < {1'b0, h_i}) ? ys[YW-1:0] : YW'(h_i - 1'b1);
  end

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    done_d = done_q;
    if (restart_i) begin
      col_d  = '0;
      row_d  = '0;
      done_d = 1'b0;
    end else if (take_i && !cmd_i) begin
      done_d = 1'b0;
      if ({1'b0, lx} + 1'b1 >= w_i) begin
        col_d = '0;
        if ({1'b0, ly} + 1'b1 >= h_i) begin
          row_d  = '0;
          done_d = 1'b1;
        end else begin
          row_d = ly + 1'b1;
        end
      end else begin
        col_d = lx + 1'b1;
        row_d = ly;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      done_q <= 1'b0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      done_q <= done_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(restart_i) |-> !done_q && col_q == '0 && row_q == '0)
    else $error("restart did not reset raster position");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> col_q == '0 && row_q == '0)
    else $error("complete frame with nonzero position");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_i && cmd_i && !restart_i) |=> $stable(col_q) && $stable(row_q))
    else $error("query moved raster position");

endmodule

`default_nettype wire

[hw/rtl/iibm_fifo.sv]
// ----------------------------------------------------------------------------
// iibm_fifo
// Short work queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module iibm_fifo import iibm_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  work_t      data_i,
  input  wire logic  pop_i,
  output work_t      data_o,
  output logic       empty_o,
  output logic       full_o
);

  localparam int unsigned PW = $clog2(QD);

  work_t          mem_q [QD];
  logic [PW-1:0]  wp_q, rp_q;
  logic [PW:0]    cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (PW+1)'(QD));
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= (wp_q == PW'(QD-1)) ? '0 : wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= (rp_q == PW'(QD-1)) ? '0 : rp_q + 1'b1;
      end
      cnt_q <= cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && full_o))
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(pop_i && empty_o))
    else $error("queue underflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= (PW+1)'(QD))
    else $error("queue count out of range");

endmodule

`default_nettype wire

[hw/rtl/iibm_div.sv]
// ----------------------------------------------------------------------------
// iibm_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module iibm_div import iibm_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [SUMW+7:0]  num_i,
  input  wire logic [CNTW-1:0]  den_i,
  output logic                  done_o,
  output logic [MW-1:0]         quo_o
);

  localparam int unsigned NW = SUMW + 8;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0]  n_q;
  logic [CNTW:0]  rem_q;
  logic [CNTW-1:0] den_q;
  logic [CW-1:0]  cnt_q;
  logic           busy_q;
  logic [CNTW:0]  trial;

  assign trial  = {rem_q[CNTW-1:0], n_q[NW-1]};
  assign done_o = busy_q && (cnt_q == '0);
  assign quo_o  = n_q[MW-1:0];

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q && cnt_q != '0) begin
      if (trial >= {1'b0, den_q}) begin
        rem_q <= trial - {1'b0, den_q};
        n_q   <= {n_q[NW-2:0], 1'b1};
      end else begin
        rem_q <= trial;
        n_q   <= {n_q[NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(NW);
    end else if (done_o) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |-> !busy_q)
    else $error("divider restarted while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |=> busy_q)
    else $error("divider did not start");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !busy_q)
    else $error("divider did not finish");

endmodule

`default_nettype wire

[hw/rtl/iibm_back.sv]
// ----------------------------------------------------------------------------
// iibm_back
// Table memory, load update and four-corner query with mean divide.
// ----------------------------------------------------------------------------
`default_nettype none

module iibm_back import iibm_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           restart_i,
  input  wire logic           avail_i,
  input  work_t               item_i,
  output logic                pop_o,
  output logic                busy_o,
  output logic                valid_o,
  output logic [MW-1:0]       mean_o,
  output logic [SUMW-1:0]     window_sum_o,
  output logic [CNTW-1:0]     pixel_count_o,
  output logic [1:0]          status_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_LRD  = 7'b0000010,
    S_LWR  = 7'b0000100,
    S_QRD  = 7'b0001000,
    S_QACC = 7'b0010000,
    S_QDIV = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  state_e         st_q, st_d;
  logic [TW-1:0]  mem_q [MaxWidth*MaxHeight];
  logic [TW-1:0]  rd_q;
  logic [AW-1:0]  raddr;
  logic           re;
  logic [TW-1:0]  rsum_q;
  work_t          it_q;
  logic [2:0]     k_q;
  logic [1:0]     kk_q;
  logic           kv_q;
  logic [TW-1:0]  acc_q;
  logic [TW-1:0]  acc_nx;
  logic [CNTW-1:0] cnt_q;
  logic           dstart;
  logic           ddone;
  logic [MW-1:0]  quo;
  logic [TW-1:0]  wval;
  logic           cx, cy;
  logic [XW-1:0]  cxv;
  logic [YW-1:0]  cyv;
  logic           cen;
  logic [XW:0]    ex;
  logic [YW:0]    ey;

  assign wval = rsum_q + (it_q.y != '0 ? rd_q : '0) + TW'(it_q.pixel);

  // Corner order: (x1,y1) +, (x0-1,y1) -, (x1,y0-1) -, (x0-1,y0-1) +.
  always_comb begin
    cx  = k_q[0];
    cy  = k_q[1];
    cxv = cx ? it_q.x0 - 1'b1 : it_q.x1;
    cyv = cy ? it_q.y0 - 1'b1 : it_q.y1;
    cen = (!cx || it_q.x0 != '0) && (!cy || it_q.y0 != '0);
  end

  always_comb begin
    acc_nx = acc_q;
    if (kv_q) begin
      if (kk_q == 2'd1 || kk_q == 2'd2) begin
        acc_nx = acc_q - rd_q;
      end else begin
        acc_nx = acc_q + rd_q;
      end
    end
  end

  always_comb begin
    re    = 1'b0;
    raddr = {it_q.y - 1'b1, it_q.x};
    if (st_q == S_LRD) begin
      re = 1'b1;
    end else if (st_q == S_QRD) begin
      re    = 1'b1;
      raddr = {cyv, cxv};
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      rd_q <= mem_q[raddr];
    end
    if (st_q == S_LWR) begin
      mem_q[{it_q.y, it_q.x}] <= wval;
    end
  end

  assign ex = {1'b0, it_q.x1} - {1'b0, it_q.x0} + 1'b1;
  assign ey = {1'b0, it_q.y1} - {1'b0, it_q.y0} + 1'b1;

  iibm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(dstart),
    .num_i  ({acc_nx[SUMW-1:0], 8'd0}),
    .den_i  (cnt_q),
    .done_o (ddone),
    .quo_o  (quo)
  );

  always_comb begin
    st_d   = st_q;
    pop_o  = 1'b0;
    dstart = 1'b0;
    case (st_q)
      S_IDLE: begin
        if (avail_i) begin
          pop_o = 1'b1;
          if (!item_i.is_query) begin
            st_d = S_LRD;
          end else if (item_i.status != StOk) begin
            st_d = S_OUT;
          end else begin
            st_d = S_QRD;
          end
        end
      end
      S_LRD:  st_d = S_LWR;
      S_LWR:  st_d = S_IDLE;
      S_QRD:  st_d = S_QACC;
      S_QACC: begin
        if (k_q == 3'd4) begin
          dstart = 1'b1;
          st_d   = S_QDIV;
        end else begin
          st_d = S_QRD;
        end
      end
      S_QDIV: if (ddone) st_d = S_OUT;
      S_OUT:  st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      it_q   <= item_i;
      k_q    <= '0;
      acc_q  <= '0;
      mean_o <= '0;
    end
    if (st_q == S_QRD) begin
      kk_q <= k_q[1:0];
      kv_q <= cen;
      k_q  <= k_q + 1'b1;
    end
    if (st_q == S_QACC) begin
      acc_q <= acc_nx;
      cnt_q <= CNTW'(ex * ey);
    end
    if (st_q == S_QDIV && ddone) begin
      mean_o <= quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      rsum_q <= '0;
    end else begin
      st_q <= st_d;
      if (restart_i) begin
        rsum_q <= '0;
      end else if (st_q == S_LWR) begin
        rsum_q <= (it_q.x == '0 ? '0 : rsum_q) + TW'(it_q.pixel);
      end else if (st_q == S_IDLE && pop_o && !item_i.is_query && item_i.row_start) begin
        rsum_q <= '0;
      end
    end
  end

  assign busy_o = (st_q != S_IDLE);
  assign valid_o = (st_q == S_OUT);
  always_comb begin
    status_o      = it_q.status;
    window_sum_o  = acc_q[SUMW-1:0];
    pixel_count_o = cnt_q;
    if (it_q.status != StOk) begin
      window_sum_o  = '0;
      pixel_count_o = '0;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_LRD |=> st_q == S_LWR)
    else $error("load sequence broken");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> st_q == S_IDLE)
    else $error("result held more than one cycle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> st_q == S_IDLE)
    else $error("pop while busy");

endmodule

`default_nettype wire

[hw/rtl/integral_image_box_mean.sv]
// ----------------------------------------------------------------------------
// integral_image_box_mean
// Summed-area table box mean over a loaded frame.
// Load: the table engine finishes each pixel (pop, read above, write) before
// it pops the next item. Query: 4 table reads plus a 26-step divide; rejected
// queries go from pop straight to the result strobe.
// busy rises only when the 2-entry queue is full. Results cannot be held.
// Reset clears position and row sum; the table is undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module integral_image_box_mean import iibm_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire logic          cmd_i,
  input  wire logic [7:0]    pixel_i,
  input  wire logic [XW-1:0] query_x_i,
  input  wire logic [YW-1:0] query_y_i,
  input  wire logic          cfg_we_i,
  input  wire logic [1:0]    cfg_idx_i,
  input  wire logic [9:0]    cfg_data_i,
  output logic               done_o,
  output logic [MW-1:0]      mean_o,
  output logic [SUMW-1:0]    window_sum_o,
  output logic [CNTW-1:0]    pixel_count_o,
  output logic [1:0]         status_o
);

  logic [9:0] fw_q, fh_q;
  logic [3:0] hs_q;
  logic       restart;
  logic       take;
  logic [XW:0] w;
  logic [YW:0] h;
  logic [3:0]  r;
  work_t      item, qitem;
  logic       qempty, qfull, pop, bbusy;

  assign restart = cfg_we_i && (cfg_idx_i == CfgWidth || cfg_idx_i == CfgHeight ||
                                cfg_idx_i == CfgHalf);
  assign busy = qfull;
  assign take = start && !busy;

  always_comb begin
    w = (fw_q == '0) ? (XW+1)'(1) : (fw_q > 10'(MaxWidth)) ? (XW+1)'(MaxWidth) : (XW+1)'(fw_q);
    h = (fh_q == '0) ? (YW+1)'(1) : (fh_q > 10'(MaxHeight)) ? (YW+1)'(MaxHeight) : (YW+1)'(fh_q);
    r = (hs_q > 4'(MaxHalf)) ? 4'(MaxHalf) : hs_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= 10'd512;
      fh_q <= 10'd512;
      hs_q <= 4'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgWidth:  fw_q <= cfg_data_i;
        CfgHeight: fh_q <= cfg_data_i;
        CfgHalf:   hs_q <= cfg_data_i[3:0];
        default:   ;
      endcase
    end
  end

  iibm_front u_front (
    .clk_i, .rst_ni,
    .restart_i(restart), .take_i(take),
    .cmd_i, .pixel_i, .query_x_i, .query_y_i,
    .w_i(w), .h_i(h), .r_i(r), .item_o(item)
  );

  iibm_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i(take), .data_i(item), .pop_i(pop),
    .data_o(qitem), .empty_o(qempty), .full_o(qfull)
  );

  iibm_back u_back (
    .clk_i, .rst_ni,
    .restart_i(restart), .avail_i(!qempty), .item_i(qitem),
    .pop_o(pop), .busy_o(bbusy), .valid_o(done_o),
    .mean_o, .window_sum_o, .pixel_count_o, .status_o
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != StOk) |-> window_sum_o == '0 && pixel_count_o == '0)
    else $error("flagged result with payload");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == StOk) |-> pixel_count_o != '0)
    else $error("ok result with empty window");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> bbusy)
    else $error("result while back idle");

endmodule

`default_nettype wire
